// ===== rtl/core/owbm_pkg.sv =====
package owbm_pkg;

    // timer width of the slot and reset phase counter
    localparam int TIMER_BITS = 10;
    localparam int CFG_W      = 10;
    localparam int CFG_COUNT  = 8;
    localparam int ADDR_W     = 5;
    localparam int DATA_W     = 32;
    localparam int LEN_W      = (TIMER_BITS + 1 > CFG_W) ? TIMER_BITS + 1 : CFG_W;

    typedef logic [LEN_W-1:0] len_t;

    localparam len_t MAX_LEN      = LEN_W'(2 ** TIMER_BITS);
    localparam len_t PRESENCE_WAIT = LEN_W'(100);
    localparam len_t PULSE_MAX    = LEN_W'(240);
    localparam len_t RST_GUARD_LEN = LEN_W'(3);
    localparam len_t RST_REC_LEN  = LEN_W'(15);
    localparam len_t RST_WAIT_LEN = LEN_W'(3);
    localparam len_t WR_GUARD_LEN = LEN_W'(5);
    localparam len_t RD_GUARD_LEN = LEN_W'(3);

    // command codes
    localparam logic [1:0] OP_NONE  = 2'd0;
    localparam logic [1:0] OP_RESET = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    // register indexes
    localparam logic [2:0] REG_RESET_LOW   = 3'd0;
    localparam logic [2:0] REG_W1_LOW      = 3'd1;
    localparam logic [2:0] REG_W1_HIGH     = 3'd2;
    localparam logic [2:0] REG_W0_LOW      = 3'd3;
    localparam logic [2:0] REG_W0_HIGH     = 3'd4;
    localparam logic [2:0] REG_RD_LOW      = 3'd5;
    localparam logic [2:0] REG_RD_SAMPLE   = 3'd6;
    localparam logic [2:0] REG_RD_TAIL     = 3'd7;

    typedef struct packed {
        logic [CFG_W-1:0] reset_low_time;
        logic [CFG_W-1:0] write_one_low_time;
        logic [CFG_W-1:0] write_one_high_time;
        logic [CFG_W-1:0] write_zero_low_time;
        logic [CFG_W-1:0] write_zero_high_time;
        logic [CFG_W-1:0] read_low_time;
        logic [CFG_W-1:0] read_sample_delay;
        logic [CFG_W-1:0] read_tail_time;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        reset_low_time:       CFG_W'(600),
        write_one_low_time:   CFG_W'(5),
        write_one_high_time:  CFG_W'(70),
        write_zero_low_time:  CFG_W'(70),
        write_zero_high_time: CFG_W'(10),
        read_low_time:        CFG_W'(3),
        read_sample_delay:    CFG_W'(5),
        read_tail_time:       CFG_W'(60)
    };

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       presence_fail;
    } res_t;

endpackage

// ===== rtl/core/owbm_if.sv =====
interface owbm_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] tx_byte;
    logic       bus_level;

    modport source (output valid, output opcode, output tx_byte, output bus_level, input ready);
    modport sink (input valid, input opcode, input tx_byte, input bus_level, output ready);
endinterface

interface owbm_out_if;
    logic       valid;
    logic       ready;
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       presence_fail;

    modport source (output valid, output drive_low, output busy_res, output done_res,
                    output rx_byte, output presence_fail, input ready);
    modport sink (input valid, input drive_low, input busy_res, input done_res,
                  input rx_byte, input presence_fail, output ready);
endinterface

// ===== rtl/core/owbm_regs.sv =====
module owbm_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [owbm_pkg::ADDR_W-1:0]   paddr,
    input  logic [owbm_pkg::DATA_W-1:0]   pwdata,
    output logic [owbm_pkg::DATA_W-1:0]   prdata,
    output owbm_pkg::cfg_t                cfg
);

    owbm_pkg::cfg_t             cfg_reg;
    owbm_pkg::cfg_t             cfg_next;
    logic [2:0]                 idx;
    logic [owbm_pkg::CFG_W-1:0] wval;
    logic [owbm_pkg::CFG_W-1:0] rval;
    logic                       wr_en;

    assign idx   = paddr[4:2];
    assign wval  = pwdata[owbm_pkg::CFG_W-1:0];
    assign wr_en = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                owbm_pkg::REG_RESET_LOW: cfg_next.reset_low_time       = wval;
                owbm_pkg::REG_W1_LOW:    cfg_next.write_one_low_time   = wval;
                owbm_pkg::REG_W1_HIGH:   cfg_next.write_one_high_time  = wval;
                owbm_pkg::REG_W0_LOW:    cfg_next.write_zero_low_time  = wval;
                owbm_pkg::REG_W0_HIGH:   cfg_next.write_zero_high_time = wval;
                owbm_pkg::REG_RD_LOW:    cfg_next.read_low_time        = wval;
                owbm_pkg::REG_RD_SAMPLE: cfg_next.read_sample_delay    = wval;
                default:                 cfg_next.read_tail_time       = wval;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            owbm_pkg::REG_RESET_LOW: rval = cfg_reg.reset_low_time;
            owbm_pkg::REG_W1_LOW:    rval = cfg_reg.write_one_low_time;
            owbm_pkg::REG_W1_HIGH:   rval = cfg_reg.write_one_high_time;
            owbm_pkg::REG_W0_LOW:    rval = cfg_reg.write_zero_low_time;
            owbm_pkg::REG_W0_HIGH:   rval = cfg_reg.write_zero_high_time;
            owbm_pkg::REG_RD_LOW:    rval = cfg_reg.read_low_time;
            owbm_pkg::REG_RD_SAMPLE: rval = cfg_reg.read_sample_delay;
            default:                 rval = cfg_reg.read_tail_time;
        endcase
    end

    assign prdata = owbm_pkg::DATA_W'(rval);
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= owbm_pkg::CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== rtl/core/owbm_seq.sv =====
module owbm_seq (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           step,
    input  logic [1:0]     opcode,
    input  logic [7:0]     tx_byte,
    input  logic           bus_level,
    input  owbm_pkg::cfg_t cfg,
    output owbm_pkg::res_t res
);

    localparam logic [3:0] PH_IDLE     = 4'd0;
    localparam logic [3:0] PH_R_GUARD  = 4'd1;
    localparam logic [3:0] PH_R_LOW    = 4'd2;
    localparam logic [3:0] PH_R_REC    = 4'd3;
    localparam logic [3:0] PH_R_WAIT   = 4'd4;
    localparam logic [3:0] PH_R_DETECT = 4'd5;
    localparam logic [3:0] PH_R_PULSE  = 4'd6;
    localparam logic [3:0] PH_W_GUARD  = 4'd7;
    localparam logic [3:0] PH_W_LOW    = 4'd8;
    localparam logic [3:0] PH_W_HIGH   = 4'd9;
    localparam logic [3:0] PH_RD_GUARD = 4'd10;
    localparam logic [3:0] PH_RD_LOW   = 4'd11;
    localparam logic [3:0] PH_RD_WAIT  = 4'd12;
    localparam logic [3:0] PH_RD_TAIL  = 4'd13;

    logic [3:0]                      phase_reg, phase_next;
    logic [owbm_pkg::TIMER_BITS-1:0] tick_reg, tick_next;
    logic [2:0]                      bit_reg, bit_next;
    logic [7:0]                      shift_reg, shift_next;
    logic [7:0]                      rx_reg, rx_next;
    logic                            pres_reg, pres_next;

    owbm_pkg::len_t tc;
    owbm_pkg::len_t len;
    logic           drive;
    logic           busy;
    logic           done;

    // zero acts as one tick, long times saturate at the timer range
    function automatic owbm_pkg::len_t clamp_len(input logic [owbm_pkg::CFG_W-1:0] v);
        owbm_pkg::len_t ext;
        ext = owbm_pkg::LEN_W'(v);
        if (ext == '0)
            return owbm_pkg::LEN_W'(1);
        else if (ext > owbm_pkg::MAX_LEN)
            return owbm_pkg::MAX_LEN;
        else
            return ext;
    endfunction

    always_comb
    begin
        phase_next = phase_reg;
        tc         = owbm_pkg::LEN_W'(tick_reg);
        bit_next   = bit_reg;
        shift_next = shift_reg;
        rx_next    = rx_reg;
        pres_next  = pres_reg;
        drive      = 1'b0;
        busy       = 1'b0;
        done       = 1'b0;
        len        = owbm_pkg::LEN_W'(1);

        if (phase_reg == PH_IDLE && opcode != owbm_pkg::OP_NONE)
        begin
            tc       = '0;
            bit_next = 3'd0;
            case (opcode)
                owbm_pkg::OP_RESET: phase_next = PH_R_GUARD;
                owbm_pkg::OP_WRITE:
                begin
                    phase_next = PH_W_GUARD;
                    shift_next = tx_byte;
                end
                default:
                begin
                    phase_next = PH_RD_GUARD;
                    shift_next = 8'd0;
                end
            endcase
        end

        if (phase_next != PH_IDLE)
        begin
            busy = 1'b1;
            if (phase_next == PH_R_DETECT)
            begin
                if (!bus_level)
                begin
                    // first low sample counts as tick one of the pulse
                    phase_next = PH_R_PULSE;
                    tc         = owbm_pkg::LEN_W'(1);
                end
                else
                begin
                    tc = tc + owbm_pkg::LEN_W'(1);
                    if (tc >= owbm_pkg::PRESENCE_WAIT)
                    begin
                        pres_next  = 1'b1;
                        phase_next = PH_IDLE;
                        tc         = '0;
                        done       = 1'b1;
                    end
                end
            end
            else if (phase_next == PH_R_PULSE)
            begin
                if (bus_level)
                begin
                    pres_next  = 1'b0;
                    phase_next = PH_IDLE;
                    tc         = '0;
                    done       = 1'b1;
                end
                else
                begin
                    tc = tc + owbm_pkg::LEN_W'(1);
                    if (tc >= owbm_pkg::PULSE_MAX)
                    begin
                        pres_next  = 1'b1;
                        phase_next = PH_IDLE;
                        tc         = '0;
                        done       = 1'b1;
                    end
                end
            end
            else
            begin
                case (phase_next)
                    PH_R_GUARD:  len = owbm_pkg::RST_GUARD_LEN;
                    PH_R_LOW:    len = clamp_len(cfg.reset_low_time);
                    PH_R_REC:    len = owbm_pkg::RST_REC_LEN;
                    PH_R_WAIT:   len = owbm_pkg::RST_WAIT_LEN;
                    PH_W_GUARD:  len = owbm_pkg::WR_GUARD_LEN;
                    PH_W_LOW:    len = shift_next[0] ? clamp_len(cfg.write_one_low_time)
                                                     : clamp_len(cfg.write_zero_low_time);
                    PH_W_HIGH:   len = shift_next[0] ? clamp_len(cfg.write_one_high_time)
                                                     : clamp_len(cfg.write_zero_high_time);
                    PH_RD_GUARD: len = owbm_pkg::RD_GUARD_LEN;
                    PH_RD_LOW:   len = clamp_len(cfg.read_low_time);
                    PH_RD_WAIT:  len = clamp_len(cfg.read_sample_delay);
                    PH_RD_TAIL:  len = clamp_len(cfg.read_tail_time);
                    default:     len = owbm_pkg::LEN_W'(1);
                endcase

                drive = (phase_next == PH_R_LOW) || (phase_next == PH_W_LOW) ||
                        (phase_next == PH_RD_LOW);

                // sample on the first tail tick
                if (phase_next == PH_RD_TAIL && tc == '0)
                    shift_next = {bus_level, shift_next[7:1]};

                tc = tc + owbm_pkg::LEN_W'(1);
                if (tc >= len)
                begin
                    tc = '0;
                    case (phase_next)
                        PH_R_GUARD:  phase_next = PH_R_LOW;
                        PH_R_LOW:    phase_next = PH_R_REC;
                        PH_R_REC:    phase_next = PH_R_WAIT;
                        PH_R_WAIT:   phase_next = PH_R_DETECT;
                        PH_W_GUARD:  phase_next = PH_W_LOW;
                        PH_W_LOW:    phase_next = PH_W_HIGH;
                        PH_W_HIGH:
                        begin
                            shift_next = {1'b0, shift_next[7:1]};
                            if (bit_next == 3'd7)
                            begin
                                bit_next   = 3'd0;
                                phase_next = PH_IDLE;
                                done       = 1'b1;
                            end
                            else
                            begin
                                bit_next   = bit_next + 3'd1;
                                phase_next = PH_W_LOW;
                            end
                        end
                        PH_RD_GUARD: phase_next = PH_RD_LOW;
                        PH_RD_LOW:   phase_next = PH_RD_WAIT;
                        PH_RD_WAIT:  phase_next = PH_RD_TAIL;
                        PH_RD_TAIL:
                        begin
                            if (bit_next == 3'd7)
                            begin
                                bit_next   = 3'd0;
                                rx_next    = shift_next;
                                phase_next = PH_IDLE;
                                done       = 1'b1;
                            end
                            else
                            begin
                                bit_next   = bit_next + 3'd1;
                                phase_next = PH_RD_GUARD;
                            end
                        end
                        default:
                        begin
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                        end
                    endcase
                end
            end
        end

        tick_next = tc[owbm_pkg::TIMER_BITS-1:0];
    end

    assign res.drive_low     = drive;
    assign res.busy_res      = busy;
    assign res.done_res      = done;
    assign res.rx_byte       = rx_next;
    assign res.presence_fail = pres_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            tick_reg  <= '0;
            bit_reg   <= 3'd0;
            shift_reg <= 8'd0;
            rx_reg    <= 8'd0;
            pres_reg  <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            rx_reg    <= rx_next;
            pres_reg  <= pres_next;
        end
    end

    a_idle_no_drive: assert property (@(posedge clk) disable iff (!rst_n)
        (step && phase_reg == PH_IDLE && opcode == owbm_pkg::OP_NONE) |-> (!drive && !busy))
        else $error("idle tick with no command drove the bus");

    a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (step && done) |=> (phase_reg == PH_IDLE))
        else $error("command finished but sequencer not idle");

    a_bit_zero_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE) |-> (bit_reg == 3'd0 && tick_reg == '0))
        else $error("idle with stale bit or tick count");

endmodule

// ===== rtl/core/one_wire_bus_master.sv =====
// Output: the result for a tick item sits in the output register in the cycle after it is accepted.
// Throughput: one item per cycle; a new item is taken whenever the output register is empty
// or being drained in the same cycle, so the sequencer step is the only work per item.
// Reset (rst_n low, asynchronous): sequencer idle, counters, shift and receive bytes cleared,
// presence status 0, timing registers at their defaults, output register empty.
module one_wire_bus_master (
    input  logic                         clk,
    input  logic                         rst_n,
    owbm_in_if.sink                      item_in,
    owbm_out_if.source                   result_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [owbm_pkg::ADDR_W-1:0]  paddr,
    input  logic [owbm_pkg::DATA_W-1:0]  pwdata,
    output logic [owbm_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);

    owbm_pkg::cfg_t cfg;
    owbm_pkg::res_t res;
    owbm_pkg::res_t res_reg;
    logic           out_valid_reg, out_valid_next;
    logic           in_ready;
    logic           step;

    assign pready = 1'b1;

    owbm_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    assign in_ready      = !out_valid_reg || result_out.ready;
    assign item_in.ready = in_ready;
    assign step          = item_in.valid && in_ready;

    owbm_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .opcode    (item_in.opcode),
        .tx_byte   (item_in.tx_byte),
        .bus_level (item_in.bus_level),
        .cfg       (cfg),
        .res       (res)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (step)
            out_valid_next = 1'b1;
        else if (result_out.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
            res_reg <= res;
    end

    assign result_out.valid         = out_valid_reg;
    assign result_out.drive_low     = res_reg.drive_low;
    assign result_out.busy_res      = res_reg.busy_res;
    assign result_out.done_res      = res_reg.done_res;
    assign result_out.rx_byte       = res_reg.rx_byte;
    assign result_out.presence_fail = res_reg.presence_fail;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result_out.ready) |-> !item_in.ready)
        else $error("input taken while a result is stalled");

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.done_res) |-> res_reg.busy_res)
        else $error("done without busy");

    a_drive_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.drive_low) |-> res_reg.busy_res)
        else $error("bus driven low while not busy");

endmodule
